[hdl/assert_macros.svh]
// Assertion helpers for the RTL (used by mqfb_ctrl); each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define MQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/mqfb_pkg.sv]
package mqfb_pkg;

  // Default sizes
  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ITEM_BITS_DEF   = 16;

  // Fixed field widths
  localparam int CMD_W  = 2;
  localparam int QIDX_W = 4;
  localparam int ID_W   = 16;
  localparam int STS_W  = 2;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] QUEUES_IN_USE_RST = CFG_W'(8);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_BAD_INDEX = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY     = 2'd2;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [QIDX_W-1:0] queue_index;
    logic [ID_W-1:0]   item_id;
  } mqfb_req_t;

  typedef struct packed {
    logic [ID_W-1:0]  item_id_res;
    logic [STS_W-1:0] status;
    logic             last;
  } mqfb_res_t;

  // Controller -> datapath
  typedef struct packed {
    logic             load;      // latch a new request
    logic             push;      // write tail, bump fill count
    logic             pop;       // read head, advance head, drop fill count
    logic             emit;      // result strobe
    logic             emit_ram;  // result item comes from the store
    logic [STS_W-1:0] status;
    logic             last;
  } mqfb_ctl_t;

  // Datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             bad;
    logic             empty;
    logic             full;
  } mqfb_sts_t;

endpackage

[hdl/mqfb_ram.sv]
module mqfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[hdl/mqfb_ctrl.sv]
`include "assert_macros.svh"

module mqfb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  mqfb_pkg::mqfb_sts_t sts_i,
  output mqfb_pkg::mqfb_ctl_t ctl_o
);
  import mqfb_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  logic [1:0] state_q, state_d;
  logic       last_item;

  assign busy_o    = (state_q != S_IDLE);
  assign last_item = (sts_i.command == CMD_DEQ) || sts_i.empty;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_IDLE;
        priority if (sts_i.command == CMD_UNUSED) begin
          // no result
        end else if (sts_i.bad) begin
          ctl_o.emit   = 1'b1;
          ctl_o.last   = 1'b1;
          ctl_o.status = STS_BAD_INDEX;
        end else if (sts_i.command == CMD_ENQ) begin
          ctl_o.emit   = 1'b1;
          ctl_o.last   = 1'b1;
          ctl_o.push   = !sts_i.full;
          ctl_o.status = sts_i.full ? STS_FULL : STS_OK;
        end else if (sts_i.empty) begin
          ctl_o.emit   = 1'b1;
          ctl_o.last   = 1'b1;
          ctl_o.status = STS_EMPTY;
        end else begin
          ctl_o.pop = 1'b1;
          state_d   = S_STREAM;
        end
      end
      S_STREAM: begin
        // empty already reflects the pop of the item now on the read port
        ctl_o.emit     = 1'b1;
        ctl_o.emit_ram = 1'b1;
        ctl_o.status   = STS_OK;
        ctl_o.last     = last_item;
        if (last_item) begin
          state_d = S_IDLE;
        end else begin
          ctl_o.pop = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `MQ_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `MQ_ASSERT_NEXT(a_pop_then_emit, ctl_o.pop, ctl_o.emit && ctl_o.emit_ram)
  `MQ_ASSERT(a_err_is_last, ctl_o.emit |-> (ctl_o.last || ctl_o.status == STS_OK))
  `MQ_ASSERT(a_push_pop_excl, !(ctl_o.push && ctl_o.pop))

endmodule

[hdl/mqfb_dp.sv]
module mqfb_dp #(
  parameter int NUM_QUEUES  = mqfb_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqfb_pkg::QUEUE_DEPTH_DEF,
  parameter int ITEM_BITS   = mqfb_pkg::ITEM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mqfb_pkg::CFG_W-1:0]     cfg_data_i,
  input  mqfb_pkg::mqfb_req_t            req_i,
  input  mqfb_pkg::mqfb_ctl_t            ctl_i,
  output mqfb_pkg::mqfb_sts_t            sts_o,
  output mqfb_pkg::mqfb_res_t            res_o
);
  import mqfb_pkg::*;

  localparam int QW       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW       = $clog2(QUEUE_DEPTH);
  localparam int FW       = $clog2(QUEUE_DEPTH + 1);
  localparam int StoreW   = (ITEM_BITS < ID_W) ? ITEM_BITS : ID_W;
  localparam int RamDepth = NUM_QUEUES * (2 ** SW);
  localparam int AddrW    = $clog2(RamDepth);

  mqfb_req_t          req_q;
  logic [CFG_W-1:0]   qiu_q;
  logic [SW-1:0]      head_q [NUM_QUEUES];
  logic [FW-1:0]      fill_q [NUM_QUEUES];

  logic [CFG_W-1:0]   limit;
  logic               bad;
  logic [QW-1:0]      q;
  logic [SW-1:0]      head_sel, head_nxt, tail_slot;
  logic [FW-1:0]      fill_sel;
  logic [SW:0]        tail_sum;
  logic [QW+SW-1:0]   addr_full;
  logic [AddrW-1:0]   ram_addr;
  logic [StoreW-1:0]  ram_rdata;

  // Queue decode; a bad index never reaches the pointer arrays
  assign limit = (qiu_q > CFG_W'(NUM_QUEUES)) ? CFG_W'(NUM_QUEUES) : qiu_q;
  assign bad   = (req_q.queue_index == '0) || (req_q.queue_index > limit);
  assign q     = QW'(req_q.queue_index - QIDX_W'(1));

  assign head_sel = bad ? '0 : head_q[q];
  assign fill_sel = bad ? '0 : fill_q[q];

  assign tail_sum  = (SW+1)'(head_sel) + (SW+1)'(fill_sel);
  assign tail_slot = (tail_sum >= (SW+1)'(QUEUE_DEPTH)) ?
                     SW'(tail_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(tail_sum);
  assign head_nxt  = (head_sel == SW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + SW'(1);

  assign addr_full = ctl_i.push ? {q, tail_slot} : {q, head_sel};
  assign ram_addr  = AddrW'(addr_full);

  assign sts_o.command = req_q.command;
  assign sts_o.bad     = bad;
  assign sts_o.empty   = (fill_sel == '0);
  assign sts_o.full    = (fill_sel == FW'(QUEUE_DEPTH));

  assign res_o.item_id_res = ctl_i.emit_ram ? ID_W'(ram_rdata) : '0;
  assign res_o.status      = ctl_i.status;
  assign res_o.last        = ctl_i.last;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qiu_q <= QUEUES_IN_USE_RST;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        qiu_q <= cfg_data_i;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        if (q == QW'(i)) begin
          if (ctl_i.push) begin
            fill_q[i] <= fill_sel + FW'(1);
          end else if (ctl_i.pop) begin
            fill_q[i] <= fill_sel - FW'(1);
            head_q[i] <= head_nxt;
          end
        end
      end
    end
  end

  mqfb_ram #(
    .WIDTH (StoreW),
    .DEPTH (RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push),
    .addr_i  (ram_addr),
    .wdata_i (req_q.item_id[StoreW-1:0]),
    .rdata_o (ram_rdata)
  );

endmodule

[hdl/multi_queue_fifo_bank.sv]
// Enqueue, bad index, full or empty: result strobe in the cycle after accept (check state).
// Dequeue: the check state pops, the stream state emits the registered store read.
// Drain of n items: first result in the stream state, then one per cycle; busy until idle again.
// Pace set by the single-port item store: one access per cycle, read data registered.
// Reset clears head pointers, fill counts and the FSM, sets queues_in_use to 8; the store
// holds no reset and needs no clearing pass. Results cannot be stalled by the receiver.
module multi_queue_fifo_bank #(
  parameter int NUM_QUEUES  = mqfb_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqfb_pkg::QUEUE_DEPTH_DEF,
  parameter int ITEM_BITS   = mqfb_pkg::ITEM_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  mqfb_pkg::mqfb_req_t        req_i,
  // result channel, one-cycle strobe
  output logic                       result_valid_o,
  output mqfb_pkg::mqfb_res_t        res_o,
  // queues_in_use register
  input  logic                       cfg_we_i,
  input  logic [mqfb_pkg::CFG_W-1:0] cfg_data_i
);
  import mqfb_pkg::*;

  mqfb_ctl_t ctl;
  mqfb_sts_t sts;

  // Controller: accept, check the request, then either answer at once (enqueue /
  // errors), give no result (unused command), or stream pops out of the store one per cycle.
  mqfb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  // Datapath: request latch, per-queue head/fill registers, shared store.
  mqfb_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ITEM_BITS   (ITEM_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .res_o      (res_o)
  );

  // Strobe comes straight from the controller's emit decode.
  assign result_valid_o = ctl.emit;

endmodule

[tb/sv/multi_queue_fifo_bank_checker.sv]
module multi_queue_fifo_bank_checker #(
  parameter int NUM_QUEUES  = mqfb_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  mqfb_pkg::mqfb_req_t        req_i,
  input  logic                       result_valid_i,
  input  mqfb_pkg::mqfb_res_t        res_i,
  input  logic                       cfg_we_i,
  input  logic [mqfb_pkg::CFG_W-1:0] cfg_data_i,
  output int                         mismatches_o,
  output int                         pending_o
);
  import mqfb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  // shadow of the queue bank
  logic [ID_W-1:0]  slot_data [NUM_QUEUES][QUEUE_DEPTH];
  logic [PTR_W-1:0] head_slot [NUM_QUEUES];
  logic [PTR_W:0]   held_count [NUM_QUEUES];
  logic [CFG_W-1:0] active_queues;

  mqfb_res_t awaited_results [$];
  int        mismatches;

  task automatic push_result(input logic [ID_W-1:0] id, input logic [STS_W-1:0] sts,
                             input logic lst);
    mqfb_res_t r;
    r.item_id_res = id;
    r.status      = sts;
    r.last        = lst;
    awaited_results.push_back(r);
  endtask

  // queue bank behavior for one accepted request
  task automatic apply_request(input mqfb_req_t r);
    int lim;
    int q;
    int n;
    int slot;
    lim = (int'(active_queues) > NUM_QUEUES) ? NUM_QUEUES : int'(active_queues);
    if (r.command == CMD_UNUSED) return;
    if (r.queue_index == '0 || int'(r.queue_index) > lim) begin
      push_result('0, STS_BAD_INDEX, 1'b1);
      return;
    end
    q = int'(r.queue_index) - 1;
    n = int'(held_count[q]);
    if (r.command == CMD_ENQ) begin
      if (n >= QUEUE_DEPTH) begin
        push_result('0, STS_FULL, 1'b1);
      end else begin
        slot = (int'(head_slot[q]) + n) % QUEUE_DEPTH;
        slot_data[q][slot] = r.item_id;
        held_count[q] = held_count[q] + 1'b1;
        push_result('0, STS_OK, 1'b1);
      end
      return;
    end
    if (n == 0) begin
      push_result('0, STS_EMPTY, 1'b1);
      return;
    end
    if (r.command == CMD_DEQ) begin
      push_result(slot_data[q][head_slot[q]], STS_OK, 1'b1);
      head_slot[q] = PTR_W'((int'(head_slot[q]) + 1) % QUEUE_DEPTH);
      held_count[q] = held_count[q] - 1'b1;
      return;
    end
    // drain: whole queue, head first
    for (int k = 0; k < n; k++) begin
      slot = (int'(head_slot[q]) + k) % QUEUE_DEPTH;
      push_result(slot_data[q][slot], STS_OK, k == n - 1);
    end
    head_slot[q] = PTR_W'((int'(head_slot[q]) + n) % QUEUE_DEPTH);
    held_count[q] = '0;
  endtask

  task automatic check_result(input mqfb_res_t got);
    mqfb_res_t want;
    if (awaited_results.size() == 0) begin
      $error("result with none outstanding: item %h status %0d last %0d",
             got.item_id_res, got.status, got.last);
      mismatches++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.item_id_res !== want.item_id_res) begin
      $error("item_id_res expected %h actual %h", want.item_id_res, got.item_id_res);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status expected %0d actual %0d", want.status, got.status);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last expected %0d actual %0d", want.last, got.last);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_slot[q]  = '0;
        held_count[q] = '0;
      end
      active_queues = QUEUES_IN_USE_RST;
      awaited_results.delete();
    end else begin
      // results at this edge belong to requests accepted earlier
      if (result_valid_i) check_result(res_i);
      if (cfg_we_i) active_queues = cfg_data_i;
      if (start_i && !busy_i) apply_request(req_i);
    end
    mismatches_o <= mismatches;
    pending_o    <= awaited_results.size();
  end

endmodule

[tb/sv/multi_queue_fifo_bank_test.sv]
module multi_queue_fifo_bank_test;
  import mqfb_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  mqfb_req_t        req = '0;
  logic             result_valid;
  mqfb_res_t        res;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  int               mismatches;
  int               pending;

  // stimulus-side copy of queues_in_use, used to aim indices at live queues
  int               queues_cfg = 8;

  // per-phase setup: register value, sender idle percentage, request count
  localparam int NUM_PHASES = 5;
  localparam int PHASE_CFG  [NUM_PHASES] = '{8, 1, 0, 5, 15};
  localparam int PHASE_IDLE [NUM_PHASES] = '{0, 83, 0, 0, 34};
  localparam int PHASE_REQS [NUM_PHASES] = '{100, 100, 20, 100, 100};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  multi_queue_fifo_bank uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid),
    .res_o          (res),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data)
  );

  multi_queue_fifo_bank_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .result_valid_i (result_valid),
    .res_i          (res),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // Issue one request. Called at a rising edge; returns at the edge that
  // accepted it, with start still high so back-to-back requests never
  // drop start in between. A random idle gap goes first when asked.
  task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [QIDX_W-1:0] qi,
                               input logic [ID_W-1:0] id, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    req.command     <= cmd;
    req.queue_index <= qi;
    req.item_id     <= id;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Wait until the block is quiet: nothing outstanding and not busy.
  // An ignored command makes no result but can still hold the block, so a
  // short pause follows, longer than a full drain.
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_queues_in_use(input int value);
    wait_quiet();
    cfg_we     <= 1'b1;
    cfg_data   <= CFG_W'(value);
    queues_cfg = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random request, mostly aimed at addressable queues. Enqueue outweighs
  // dequeue and drain so queues grow toward full now and then.
  task automatic issue_random(input int idle_pct, output bit counted);
    int               lim;
    int               roll;
    logic [CMD_W-1:0] cmd;
    logic [QIDX_W-1:0] qi;
    lim  = (queues_cfg > NUM_QUEUES_DEF) ? NUM_QUEUES_DEF : queues_cfg;
    roll = $urandom_range(99);
    if (roll < 4)       cmd = CMD_UNUSED;
    else if (roll < 56) cmd = CMD_ENQ;
    else if (roll < 84) cmd = CMD_DEQ;
    else                cmd = CMD_DRAIN;
    if (lim == 0 || $urandom_range(99) < 6) qi = QIDX_W'($urandom_range(15));
    else                                    qi = QIDX_W'($urandom_range(lim, 1));
    issue_request(cmd, qi, ID_W'($urandom), idle_pct);
    counted = (cmd != CMD_UNUSED);
  endtask

  initial begin
    int done_reqs;
    bit counted;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_queues_in_use(8);

    // Directed: field extremes, every command, empty queue on dequeue and
    // drain, indices zero and past the limit, the unused command, a queue
    // filled to the brim, an enqueue dropped on full, and a maximal drain.
    issue_request(CMD_ENQ,    4'd1,  16'hFFFF, 0);
    issue_request(CMD_ENQ,    4'd8,  16'h0000, 0);
    issue_request(CMD_DEQ,    4'd1,  16'h1234, 0);
    issue_request(CMD_DEQ,    4'd1,  16'h0000, 0);
    issue_request(CMD_DRAIN,  4'd1,  16'hFFFF, 0);
    issue_request(CMD_DEQ,    4'd0,  16'h0000, 0);
    issue_request(CMD_ENQ,    4'd9,  16'hFFFF, 0);
    issue_request(CMD_DRAIN,  4'd15, 16'h0000, 0);
    issue_request(CMD_UNUSED, 4'd2,  16'hA5A5, 0);
    issue_request(CMD_DRAIN,  4'd8,  16'h0000, 0);
    for (int k = 0; k < QUEUE_DEPTH_DEF; k++)
      issue_request(CMD_ENQ, 4'd2, ID_W'(16'h8001 + k * 16'h1111), 0);
    issue_request(CMD_ENQ,    4'd2,  16'h7777, 0);
    issue_request(CMD_DRAIN,  4'd2,  16'h0000, 0);

    // Random phases, each under its own register value and idle pattern.
    // Zero and 15 are out of the nominal range: zero leaves no queue addressable, 15 exercises the clamping.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_queues_in_use(PHASE_CFG[p]);
      done_reqs = 0;
      while (done_reqs < PHASE_REQS[p]) begin
        issue_random(PHASE_IDLE[p], counted);
        if (counted) done_reqs++;
      end
    end

    wait_quiet();
    if (mismatches == 0 && pending == 0) begin
      $display("multi_queue_fifo_bank_test: done, clean");
    end else begin
      $display("multi_queue_fifo_bank_test: done, errors");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("multi_queue_fifo_bank_test: done, errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mqfb_pkg.sv
hdl/mqfb_ram.sv
hdl/mqfb_ctrl.sv
hdl/mqfb_dp.sv
hdl/multi_queue_fifo_bank.sv
tb/sv/multi_queue_fifo_bank_checker.sv
tb/sv/multi_queue_fifo_bank_test.sv
